### hdl/mde_pkg.sv
// Package for the MIPS32 decode/execute block: opcode and function codes,
// request and result item types.
// No dependencies.
`default_nettype none

package mde_pkg;

  // Primary opcodes (instruction bits 31:26)
  typedef enum logic [5:0] {
    OP_RTYPE = 6'h00,
    OP_J     = 6'h02,
    OP_JAL   = 6'h03,
    OP_BEQ   = 6'h04,
    OP_BNE   = 6'h05,
    OP_ADDI  = 6'h08,
    OP_ADDIU = 6'h09,
    OP_SLTI  = 6'h0A,
    OP_SLTIU = 6'h0B,
    OP_ANDI  = 6'h0C,
    OP_ORI   = 6'h0D,
    OP_LUI   = 6'h0F,
    OP_LW    = 6'h23,
    OP_LBU   = 6'h24,
    OP_LHU   = 6'h25,
    OP_SB    = 6'h28,
    OP_SH    = 6'h29,
    OP_SW    = 6'h2B,
    OP_LL    = 6'h30,
    OP_SC    = 6'h38
  } opcode_e;

  // R-type function codes (instruction bits 5:0)
  typedef enum logic [5:0] {
    FN_SLL  = 6'h00,
    FN_SRL  = 6'h02,
    FN_JR   = 6'h08,
    FN_ADD  = 6'h20,
    FN_ADDU = 6'h21,
    FN_SUB  = 6'h22,
    FN_SUBU = 6'h23,
    FN_AND  = 6'h24,
    FN_OR   = 6'h25,
    FN_NOR  = 6'h27,
    FN_SLT  = 6'h2A,
    FN_SLTU = 6'h2B
  } funct_e;

  localparam logic [4:0]  LinkReg = 5'd31;
  localparam logic [31:0] PcStep  = 32'd4;

  // Input item
  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] inst_pc;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
  } mde_req_t;

  // Result item
  typedef struct packed {
    logic [31:0] alu_result;
    logic        branch_flag;
    logic        branch_cond;
    logic [31:0] branch_target;
    logic        jump_flag;
    logic [31:0] jump_target;
    logic        reg_write;
    logic [4:0]  write_reg;
    logic        mem_read;
    logic        mem_write;
    logic        mem_to_reg;
  } mde_res_t;

endpackage

`default_nettype wire

### hdl/mde_in_if.sv
// Input channel of the decode/execute block: valid/ready plus instruction item.
// No dependencies.
`default_nettype none

interface mde_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [31:0] inst_pc;
  logic [31:0] rs_value;
  logic [31:0] rt_value;

  modport source (output valid, output instruction, output inst_pc,
                  output rs_value, output rt_value, input ready);
  modport sink   (input valid, input instruction, input inst_pc,
                  input rs_value, input rt_value, output ready);
endinterface

`default_nettype wire

### hdl/mde_out_if.sv
// Result channel of the decode/execute block: valid/ready plus result item.
// No dependencies.
`default_nettype none

interface mde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] alu_result;
  logic        branch_flag;
  logic        branch_cond;
  logic [31:0] branch_target;
  logic        jump_flag;
  logic [31:0] jump_target;
  logic        reg_write;
  logic [4:0]  write_reg;
  logic        mem_read;
  logic        mem_write;
  logic        mem_to_reg;

  modport source (output valid, output alu_result, output branch_flag,
                  output branch_cond, output branch_target, output jump_flag,
                  output jump_target, output reg_write, output write_reg,
                  output mem_read, output mem_write, output mem_to_reg,
                  input ready);
  modport sink   (input valid, input alu_result, input branch_flag,
                  input branch_cond, input branch_target, input jump_flag,
                  input jump_target, input reg_write, input write_reg,
                  input mem_read, input mem_write, input mem_to_reg,
                  output ready);
endinterface

`default_nettype wire

### hdl/mips_decode_execute_top.sv
// MIPS32 decode/execute, integer subset. Uses mde_pkg, mde_in_if, mde_out_if.
// Datapath: the input register captures an accepted item, then decode/ALU logic
// feeds the result register, whose valid flag drives the result valid output.
// Throughput: one item per cycle; the ready chain through both registers
// lets a new item enter whenever the next stage frees up.
// Reset: rst_ni (async, active low) clears both valid flags; payload is not reset.
`default_nettype none

module mips_decode_execute_top
  import mde_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mde_in_if.sink     in_i,
  mde_out_if.source  out_o
);

  logic     in_valid_q;
  mde_req_t in_req_q;
  logic     out_valid_q;
  mde_res_t out_res_q;
  mde_res_t res_d;
  logic     out_free;

  // Handshake: result register frees when empty or taken downstream
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_req_q <= '{instruction: in_i.instruction, inst_pc: in_i.inst_pc,
                    rs_value: in_i.rs_value, rt_value: in_i.rt_value};
    end
  end

  // Decode and execute
  logic [31:0] a, b, pc, pc_plus4, imm_ext;
  logic [5:0]  op_raw, fn_raw;
  opcode_e     op;
  funct_e      fn;
  logic [4:0]  rt, rd, shamt;
  logic [25:0] tgt;
  logic        is_r, is_jr;

  always_comb begin
    a        = in_req_q.rs_value;
    b        = in_req_q.rt_value;
    pc       = in_req_q.inst_pc;
    op_raw   = in_req_q.instruction[31:26];
    fn_raw   = in_req_q.instruction[5:0];
    op       = opcode_e'(op_raw);
    fn       = funct_e'(fn_raw);
    rt       = in_req_q.instruction[20:16];
    rd       = in_req_q.instruction[15:11];
    shamt    = in_req_q.instruction[10:6];
    tgt      = in_req_q.instruction[25:0];
    pc_plus4 = pc + PcStep;
    is_r     = (op == OP_RTYPE);
    is_jr    = is_r && (fn == FN_JR);

    // andi/ori zero-extend, everything else sign-extends
    if (op == OP_ANDI || op == OP_ORI) begin
      imm_ext = {16'h0000, in_req_q.instruction[15:0]};
    end else begin
      imm_ext = {{16{in_req_q.instruction[15]}}, in_req_q.instruction[15:0]};
    end

    res_d = '0;

    if (is_r) begin
      case (fn)
        FN_ADD, FN_ADDU: res_d.alu_result = a + b;
        FN_SUB, FN_SUBU: res_d.alu_result = a - b;
        FN_AND:  res_d.alu_result = a & b;
        FN_OR:   res_d.alu_result = a | b;
        FN_NOR:  res_d.alu_result = ~(a | b);
        FN_SLT:  res_d.alu_result = {31'd0, $signed(a) < $signed(b)};
        FN_SLTU: res_d.alu_result = {31'd0, a < b};
        FN_SLL:  res_d.alu_result = b << shamt;
        FN_SRL:  res_d.alu_result = b >> shamt;
        FN_JR: begin
          res_d.jump_flag   = 1'b1;
          res_d.jump_target = a;
        end
        default: res_d.alu_result = '0;
      endcase
    end else begin
      case (op)
        OP_ADDI, OP_ADDIU, OP_LW, OP_LL, OP_LBU, OP_LHU,
        OP_SW, OP_SH, OP_SB, OP_SC: res_d.alu_result = a + imm_ext;
        OP_ANDI:  res_d.alu_result = a & imm_ext;
        OP_ORI:   res_d.alu_result = a | imm_ext;
        OP_LUI:   res_d.alu_result = {in_req_q.instruction[15:0], 16'h0000};
        OP_SLTI:  res_d.alu_result = {31'd0, $signed(a) < $signed(imm_ext)};
        OP_SLTIU: res_d.alu_result = {31'd0, a < imm_ext};
        OP_BEQ, OP_BNE: begin
          res_d.branch_flag   = 1'b1;
          res_d.branch_cond   = (op == OP_BEQ) ? (a == b) : (a != b);
          res_d.branch_target = pc_plus4 + {imm_ext[29:0], 2'b00};
        end
        OP_J, OP_JAL: begin
          res_d.jump_flag   = 1'b1;
          res_d.jump_target = {pc_plus4[31:28], tgt, 2'b00};
          if (op == OP_JAL) begin
            res_d.alu_result = pc_plus4 + PcStep;
          end
        end
        default: res_d.alu_result = '0;
      endcase
    end

    // Control flags
    res_d.reg_write = !(op == OP_SW || op == OP_SH || op == OP_SB ||
                        op == OP_BEQ || op == OP_BNE || op == OP_J || is_jr);
    if (is_r) begin
      res_d.write_reg = rd;
    end else if (op == OP_JAL) begin
      res_d.write_reg = LinkReg;
    end else if (op == OP_J) begin
      res_d.write_reg = '0;
    end else begin
      res_d.write_reg = rt;
    end
    res_d.mem_read   = (op == OP_LW || op == OP_LL || op == OP_LBU || op == OP_LHU);
    res_d.mem_write  = (op == OP_SW || op == OP_SH || op == OP_SB);
    res_d.mem_to_reg = (op == OP_LW || op == OP_LL);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.alu_result    = out_res_q.alu_result;
  assign out_o.branch_flag   = out_res_q.branch_flag;
  assign out_o.branch_cond   = out_res_q.branch_cond;
  assign out_o.branch_target = out_res_q.branch_target;
  assign out_o.jump_flag     = out_res_q.jump_flag;
  assign out_o.jump_target   = out_res_q.jump_target;
  assign out_o.reg_write     = out_res_q.reg_write;
  assign out_o.write_reg     = out_res_q.write_reg;
  assign out_o.mem_read      = out_res_q.mem_read;
  assign out_o.mem_write     = out_res_q.mem_write;
  assign out_o.mem_to_reg    = out_res_q.mem_to_reg;

endmodule

`default_nettype wire
